FILE: hdl/dssa_pkg.sv
// Shared constants, types and helpers for the two-stack shared array.
package dssa_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int OPCODE_W  = 3;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 3;
  localparam int COUNT_W   = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Operation class, taken from the upper opcode bits.
  typedef enum logic [1:0] {
    K_PUSH   = 2'd0,
    K_POP    = 2'd1,
    K_PEEK   = 2'd2,
    K_MODIFY = 2'd3
  } kind_t;

  // How the controller closes an item.
  typedef enum logic [2:0] {
    FIN_PUSH      = 3'd0,
    FIN_OVERFLOW  = 3'd1,
    FIN_UNDERFLOW = 3'd2,
    FIN_READ      = 3'd3,
    FIN_HIT       = 3'd4,
    FIN_MISS      = 3'd5
  } fin_t;

  typedef struct packed {
    logic latch;
    logic rd_top;
    logic rd_first;
    logic rd_next;
    logic finish;
    fin_t fin;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  empty;
    logic  hit;
    logic  last;
    logic  out_free;
  } dp_stat_t;

  function automatic kind_t op_kind(input logic [OPCODE_W-1:0] op);
    return kind_t'(op[OPCODE_W-1:1]);
  endfunction

  function automatic logic op_second(input logic [OPCODE_W-1:0] op);
    return op[0];
  endfunction

endpackage

FILE: hdl/dssa_cmd_if.sv
// Input channel: opcode, value and match value with valid/ready.
interface dssa_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [dssa_pkg::OPCODE_W-1:0] opcode;
  logic signed [dssa_pkg::WORD_W-1:0]   value;
  logic signed [dssa_pkg::WORD_W-1:0]   match_value;

  modport source (output valid, opcode, value, match_value, input ready);
  modport sink   (input valid, opcode, value, match_value, output ready);
endinterface

FILE: hdl/dssa_rsp_if.sv
// Result channel: status, data, position and both fill counts with valid/ready.
interface dssa_rsp_if;
  logic                                valid;
  logic                                ready;
  dssa_pkg::status_t                   status;
  logic signed [dssa_pkg::WORD_W-1:0]  data;
  logic        [dssa_pkg::POS_W-1:0]   position;
  logic        [dssa_pkg::COUNT_W-1:0] count_one;
  logic        [dssa_pkg::COUNT_W-1:0] count_two;

  modport source (output valid, status, data, position, count_one, count_two, input ready);
  modport sink   (input valid, status, data, position, count_one, count_two, output ready);
endinterface

FILE: hdl/dual_stack_shared_array.sv
// Top level: two stacks in one shared memory, controller plus datapath.
//
//   channel  dir  payload                                          handshake
//   cmd      in   opcode, value, match_value                       valid/ready
//   rsp      out  status, data, position, count_one, count_two     valid/ready
//
// One transaction at a time. Push, overflow and underflow are closed from the
// execute state; pop and peek add one registered memory read; modify, hit or
// not found, does one memory read per entry scanned.
// A new transaction is taken while the previous result still waits; work on it
// holds until the result register is free. Reset (rst) empties both stacks.
module dual_stack_shared_array #(
  parameter int DEPTH = dssa_pkg::DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  dssa_cmd_if.sink   cmd,
  dssa_rsp_if.source rsp
);

  dssa_pkg::ctl_cmd_t ctl;
  dssa_pkg::dp_stat_t stat;

  dssa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .stat     (stat),
    .cmd      (ctl)
  );

  dssa_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctl),
    .stat        (stat),
    .opcode      (cmd.opcode),
    .value       (cmd.value),
    .match_value (cmd.match_value),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .data        (rsp.data),
    .position    (rsp.position),
    .count_one   (rsp.count_one),
    .count_two   (rsp.count_two)
  );

  // one transaction in flight: ready drops right after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("new transaction accepted while one is in flight");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != dssa_pkg::ST_OK |-> rsp.data == '0 && rsp.position == '0)
    else $error("failed item carries data or position");

  a_counts_fit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && DEPTH < 16 |-> ({1'b0, rsp.count_one} + {1'b0, rsp.count_two}) <= DEPTH)
    else $error("stacks overlap");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == dssa_pkg::ST_OVERFLOW && DEPTH < 16
      |-> ({1'b0, rsp.count_one} + {1'b0, rsp.count_two}) == DEPTH)
    else $error("overflow reported with free space");

endmodule

FILE: hdl/dssa_ctrl.sv
// Sequencer: accepts a transaction, steps the memory accesses, closes the result.
module dssa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dssa_pkg::dp_stat_t stat,
  output dssa_pkg::ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.fin      = dssa_pkg::FIN_PUSH;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register can take this item's answer
        if (stat.out_free) begin
          unique case (stat.kind)
            dssa_pkg::K_PUSH: begin
              cmd.finish = 1'b1;
              cmd.fin    = stat.full ? dssa_pkg::FIN_OVERFLOW : dssa_pkg::FIN_PUSH;
              state_next = S_IDLE;
            end
            dssa_pkg::K_POP, dssa_pkg::K_PEEK: begin
              if (stat.empty) begin
                cmd.finish = 1'b1;
                cmd.fin    = dssa_pkg::FIN_UNDERFLOW;
                state_next = S_IDLE;
              end else begin
                cmd.rd_top = 1'b1;
                state_next = S_READ;
              end
            end
            dssa_pkg::K_MODIFY: begin
              if (stat.empty) begin
                cmd.finish = 1'b1;
                cmd.fin    = dssa_pkg::FIN_UNDERFLOW;
                state_next = S_IDLE;
              end else begin
                cmd.rd_first = 1'b1;
                state_next   = S_SCAN;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        cmd.finish = 1'b1;
        cmd.fin    = dssa_pkg::FIN_READ;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.finish = 1'b1;
          cmd.fin    = dssa_pkg::FIN_HIT;
          state_next = S_IDLE;
        end else if (stat.last) begin
          cmd.finish = 1'b1;
          cmd.fin    = dssa_pkg::FIN_MISS;
          state_next = S_IDLE;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/dssa_dp.sv
// Datapath: shared memory, fill counters, scan index and result register.
module dssa_dp #(
  parameter int DEPTH = dssa_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dssa_pkg::ctl_cmd_t                  cmd,
  output dssa_pkg::dp_stat_t                  stat,
  input  logic        [dssa_pkg::OPCODE_W-1:0] opcode,
  input  logic signed [dssa_pkg::WORD_W-1:0]   value,
  input  logic signed [dssa_pkg::WORD_W-1:0]   match_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dssa_pkg::status_t                   status,
  output logic signed [dssa_pkg::WORD_W-1:0]   data,
  output logic        [dssa_pkg::POS_W-1:0]    position,
  output logic        [dssa_pkg::COUNT_W-1:0]  count_one,
  output logic        [dssa_pkg::COUNT_W-1:0]  count_two
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [dssa_pkg::WORD_W-1:0] mem [DEPTH];

  logic [dssa_pkg::OPCODE_W-1:0] op;
  logic [dssa_pkg::WORD_W-1:0]   val;
  logic [dssa_pkg::WORD_W-1:0]   key;
  logic [dssa_pkg::WORD_W-1:0]   rd_data;
  logic [CW-1:0]                 fill_one, fill_one_next;
  logic [CW-1:0]                 fill_two, fill_two_next;
  logic [AW-1:0]                 k;
  logic [AW-1:0]                 k_step;

  logic           second;
  logic [CW-1:0]  fill_sel;
  logic [CW:0]    fill_sum;
  logic [CW-1:0]  k_inc;
  logic [AW-1:0]  push_addr, top_addr, hit_addr, rd_addr, wr_addr;
  logic           rd_en, wr_en;

  function automatic logic [AW-1:0] scan_at(input logic sec, input logic [AW-1:0] idx);
    return sec ? (LAST_IDX - idx) : idx;
  endfunction

  assign second   = dssa_pkg::op_second(op);
  assign fill_sel = second ? fill_two : fill_one;
  assign fill_sum = {1'b0, fill_one} + {1'b0, fill_two};
  assign k_step   = k + AW'(1);
  assign k_inc    = CW'(k) + CW'(1);

  assign push_addr = second ? AW'(DEPTH_C - fill_two - CW'(1)) : AW'(fill_one);
  assign top_addr  = second ? AW'(DEPTH_C - fill_two) : AW'(fill_one - CW'(1));
  assign hit_addr  = scan_at(second, k);

  assign stat.kind     = dssa_pkg::op_kind(op);
  assign stat.full     = (fill_sum == {1'b0, DEPTH_C});
  assign stat.empty    = (fill_sel == '0);
  assign stat.hit      = (rd_data == key);
  assign stat.last     = (k_inc == fill_sel);
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    if (cmd.rd_top) begin
      rd_addr = top_addr;
    end else if (cmd.rd_first) begin
      rd_addr = scan_at(second, '0);
    end else begin
      rd_addr = scan_at(second, k_step);
    end
  end

  assign rd_en   = cmd.rd_top || cmd.rd_first || cmd.rd_next;
  assign wr_en   = cmd.finish && (cmd.fin == dssa_pkg::FIN_PUSH || cmd.fin == dssa_pkg::FIN_HIT);
  assign wr_addr = (cmd.fin == dssa_pkg::FIN_PUSH) ? push_addr : hit_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    fill_one_next = fill_one;
    fill_two_next = fill_two;
    if (cmd.finish && cmd.fin == dssa_pkg::FIN_PUSH) begin
      if (second) begin
        fill_two_next = fill_two + CW'(1);
      end else begin
        fill_one_next = fill_one + CW'(1);
      end
    end else if (cmd.finish && cmd.fin == dssa_pkg::FIN_READ
                 && dssa_pkg::op_kind(op) == dssa_pkg::K_POP) begin
      if (second) begin
        fill_two_next = fill_two - CW'(1);
      end else begin
        fill_one_next = fill_one - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_one  <= '0;
      fill_two  <= '0;
      out_valid <= 1'b0;
    end else begin
      fill_one <= fill_one_next;
      fill_two <= fill_two_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // transaction capture, scan index and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op  <= opcode;
      val <= value;
      key <= match_value;
    end
    if (cmd.rd_first) begin
      k <= '0;
    end else if (cmd.rd_next) begin
      k <= k_step;
    end
    if (cmd.finish) begin
      count_one <= dssa_pkg::COUNT_W'(fill_one_next);
      count_two <= dssa_pkg::COUNT_W'(fill_two_next);
      data      <= '0;
      position  <= '0;
      case (cmd.fin)
        dssa_pkg::FIN_OVERFLOW:  status <= dssa_pkg::ST_OVERFLOW;
        dssa_pkg::FIN_UNDERFLOW: status <= dssa_pkg::ST_UNDERFLOW;
        dssa_pkg::FIN_MISS:      status <= dssa_pkg::ST_NOT_FOUND;
        dssa_pkg::FIN_READ: begin
          status <= dssa_pkg::ST_OK;
          data   <= rd_data;
        end
        dssa_pkg::FIN_HIT: begin
          status   <= dssa_pkg::ST_OK;
          position <= dssa_pkg::POS_W'(hit_addr);
        end
        default: status <= dssa_pkg::ST_OK;
      endcase
    end
  end

endmodule
